### rtl/ckgp_pkg.sv
// ----------------------------------------------------------------------------
// ckgp_pkg
// Shared types, colors, glyph bitmaps and register codes of the checker grid
// pattern generator.
// ----------------------------------------------------------------------------
package ckgp_pkg;

  typedef struct packed {
    logic [11:0] pix_x;
    logic [11:0] pix_y;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       outside;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Enable flags that the register block hands to the pixel pipeline.
  typedef struct packed {
    logic outline_on;
    logic label_on;
  } cfg_flags_t;

  // Per-pixel flags that travel beside the coordinate dividers.
  typedef struct packed {
    logic outside;
    logic border;
    logic lab_in;
  } loc_flags_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLINE_ON = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_ON   = 3'd3;

  localparam rgb_t COL_DARK   = '{r: 8'd58,  g: 8'd61,  b: 8'd66};
  localparam rgb_t COL_LIGHT  = '{r: 8'd78,  g: 8'd82,  b: 8'd88};
  localparam rgb_t COL_GRID   = '{r: 8'd206, g: 8'd212, b: 8'd218};
  localparam rgb_t COL_MAJOR  = '{r: 8'd236, g: 8'd240, b: 8'd244};
  localparam rgb_t COL_BORDER = '{r: 8'd224, g: 8'd228, b: 8'd232};
  localparam rgb_t COL_TEXT   = '{r: 8'd232, g: 8'd236, b: 8'd240};

  localparam logic [4:0] GLYPH_ONE [0:6] = '{5'h04, 5'h0C, 5'h04, 5'h04,
                                             5'h04, 5'h04, 5'h0E};
  localparam logic [4:0] GLYPH_M   [0:6] = '{5'h00, 5'h00, 5'h1A, 5'h15,
                                             5'h15, 5'h15, 5'h15};

  // Label coverage from the label-relative glyph coordinates (in units of
  // the label scale). Glyphs sit six units apart; the middle one is blank.
  function automatic logic label_pix(input logic [11:0] qx, input logic [11:0] qy);
    logic [4:0] row;
    logic [2:0] gx;
    logic       hit;
    hit = 1'b0;
    gx  = 3'd0;
    row = 5'd0;
    if (qy < 12'd7 && qx < 12'd18) begin
      if (qx < 12'd6) begin
        gx  = qx[2:0];
        row = GLYPH_ONE[qy[2:0]];
      end else if (qx < 12'd12) begin
        gx  = 3'(qx - 12'd6);
        row = 5'd0;
      end else begin
        gx  = 3'(qx - 12'd12);
        row = GLYPH_M[qy[2:0]];
      end
      if (gx < 3'd5) begin
        hit = row[3'd4 - gx];
      end
    end
    return hit;
  endfunction

endpackage

### rtl/ckgp_udiv_pipe.sv
// ----------------------------------------------------------------------------
// ckgp_udiv_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ckgp_udiv_pipe #(
  parameter int N_W = 12,
  parameter int D_W = 13,
  parameter int Q_W = 12
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo,
  output logic [D_W-1:0] rem
);

  localparam int W = D_W + Q_W;

  logic [W-1:0]   rem_r [Q_W];
  logic [D_W-1:0] den_r [Q_W];
  logic [Q_W-1:0] quo_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [W-1:0]   r_in;
    logic [D_W-1:0] d_in;
    logic [Q_W-1:0] q_in;
    logic [W-1:0]   sh;
    logic [W-1:0]   rem_nxt;
    logic [Q_W-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign r_in = W'(num);
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[i-1];
      assign d_in = den_r[i-1];
      assign q_in = quo_r[i-1];
    end

    assign sh = W'(d_in) << (Q_W - 1 - i);

    always_comb begin
      if (r_in >= sh) begin
        rem_nxt = r_in - sh;
        quo_nxt = q_in | (Q_W'(1) << (Q_W - 1 - i));
      end else begin
        rem_nxt = r_in;
        quo_nxt = q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        den_r[i] <= d_in;
        quo_r[i] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[Q_W-1];
  assign rem = rem_r[Q_W-1][D_W-1:0];

endmodule

### rtl/ckgp_setup.sv
// ----------------------------------------------------------------------------
// ckgp_setup
// Configuration registers and the derived geometry. The cell edge comes from
// a bit-serial divider that runs after reset and after every register write;
// the label origin is a reciprocal multiply of the size.
// ----------------------------------------------------------------------------
module ckgp_setup import ckgp_pkg::*; #(
  parameter int MAX_SIZE = 4096,
  parameter int S_W      = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  busy,
  output cfg_flags_t            flags,
  output logic [S_W-1:0]        s,
  output logic [S_W-1:0]        hn,
  output logic [S_W-1:0]        w,
  output logic [S_W-1:0]        s_minus_w,
  output logic [S_W-1:0]        p,
  output logic [S_W-1:0]        cell_len,
  output logic [S_W-1:0]        org
);

  localparam logic [1:0] ST_LOAD_CELL = 2'd0;
  localparam logic [1:0] ST_RUN_CELL  = 2'd1;
  localparam logic [1:0] ST_IDLE      = 2'd2;
  localparam int CNT_W = $clog2(S_W + 1);

  logic [12:0]      tex_size_r;
  logic [12:0]      cell_count_r;
  logic             outline_on_r;
  logic             label_on_r;
  logic [1:0]       state_r;
  logic [S_W-1:0]   num_r;
  logic [12:0]      rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [S_W-1:0]   cell_r;

  logic [12:0]    den;
  logic [13:0]    trial;
  logic           ge;
  logic [S_W-1:0] num_nxt;
  logic [12:0]    rem_nxt;
  logic [S_W-1:0] s_shr3;
  logic [S_W-1:0] s_shr7;
  logic [S_W-1:0] s_shr8;
  logic [23:0]    org_prod;

  always_comb begin
    if (tex_size_r < 13'd32) begin
      s = S_W'(32);
    end else if (32'(tex_size_r) > MAX_SIZE) begin
      s = S_W'(MAX_SIZE);
    end else begin
      s = S_W'(tex_size_r);
    end
  end

  assign s_shr3    = s >> 3;
  assign s_shr7    = s >> 7;
  assign s_shr8    = s >> 8;
  assign hn        = (s > S_W'(512)) ? s : S_W'(512);
  assign w         = (s_shr8 == '0) ? S_W'(1) : s_shr8;
  assign p         = (s_shr7 == '0) ? S_W'(1) : s_shr7;
  assign s_minus_w = s - w;
  assign cell_len  = cell_r;
  assign busy      = (state_r != ST_IDLE);
  assign flags     = '{outline_on: outline_on_r, label_on: label_on_r};

  // Label origin s/24 = (s/8)/3; 683/2048 is exact enough for s/8 below 2048.
  assign org_prod = 24'(s_shr3) * 24'd683;
  assign org      = S_W'(org_prod >> 11);

  // Divisor: the cell count, where zero acts as one.
  assign den = (cell_count_r == 13'd0) ? 13'd1 : cell_count_r;

  assign trial   = {rem_r, num_r[S_W-1]};
  assign ge      = (trial >= {1'b0, den});
  assign num_nxt = {num_r[S_W-2:0], ge};
  assign rem_nxt = ge ? 13'(trial - {1'b0, den}) : trial[12:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_size_r   <= 13'd256;
      cell_count_r <= 13'd8;
      outline_on_r <= 1'b1;
      label_on_r   <= 1'b1;
      state_r      <= ST_LOAD_CELL;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TEX_SIZE:   tex_size_r   <= cfg_data;
          REG_CELL_COUNT: cell_count_r <= cfg_data;
          REG_OUTLINE_ON: outline_on_r <= cfg_data[0];
          REG_LABEL_ON:   label_on_r   <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        ST_LOAD_CELL: begin
          num_r   <= s;
          rem_r   <= 13'd0;
          cnt_r   <= CNT_W'(S_W);
          state_r <= ST_RUN_CELL;
        end
        ST_RUN_CELL: begin
          num_r <= num_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            cell_r  <= (num_nxt == '0) ? S_W'(1) : num_nxt;
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: ;
        default: state_r <= ST_IDLE;
      endcase
      // A write restarts the derivation from the new register values.
      if (cfg_we) begin
        state_r <= ST_LOAD_CELL;
      end
    end
  end

endmodule

### rtl/ckgp_locate.sv
// ----------------------------------------------------------------------------
// ckgp_locate
// Input stage and coordinate dividers: cell index and offset of the pixel,
// and its position on the label grid.
// ----------------------------------------------------------------------------
module ckgp_locate import ckgp_pkg::*; #(
  parameter int S_W = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           accept,
  input  pix_in_t        in_data,
  input  cfg_flags_t     flags,
  input  logic [S_W-1:0] s,
  input  logic [S_W-1:0] w,
  input  logic [S_W-1:0] s_minus_w,
  input  logic [S_W-1:0] p,
  input  logic [S_W-1:0] cell_len,
  input  logic [S_W-1:0] org,
  output logic           loc_valid,
  output loc_flags_t     loc_flags,
  output logic [11:0]    cx,
  output logic [11:0]    cy,
  output logic [S_W-1:0] fx,
  output logic [S_W-1:0] fy,
  output logic [11:0]    qx,
  output logic [11:0]    qy
);

  localparam int DEPTH = 12;

  logic [15:0] x16, y16, s16, w16, smw16, org16;
  loc_flags_t  flags_in;

  logic        v0_r;
  loc_flags_t  f0_r;
  logic [11:0] x0_r, y0_r, lx0_r, ly0_r;

  logic       vld_r [DEPTH];
  loc_flags_t side_r [DEPTH];

  assign x16   = 16'(in_data.pix_x);
  assign y16   = 16'(in_data.pix_y);
  assign s16   = 16'(s);
  assign w16   = 16'(w);
  assign smw16 = 16'(s_minus_w);
  assign org16 = 16'(org);

  assign flags_in.outside = (x16 >= s16) || (y16 >= s16);
  assign flags_in.border  = flags.outline_on &&
                            ((x16 < w16) || (y16 < w16) || (x16 >= smw16) || (y16 >= smw16));
  assign flags_in.lab_in  = flags.label_on && (x16 >= org16) && (y16 >= org16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_r  <= flags_in;
      x0_r  <= in_data.pix_x;
      y0_r  <= in_data.pix_y;
      lx0_r <= 12'(x16 - org16);
      ly0_r <= 12'(y16 - org16);
    end
  end

  ckgp_udiv_pipe #(.N_W(12), .D_W(S_W), .Q_W(DEPTH)) u_div_x (
    .clk(clk), .en(en), .num(x0_r), .den(cell_len), .quo(cx), .rem(fx));
  ckgp_udiv_pipe #(.N_W(12), .D_W(S_W), .Q_W(DEPTH)) u_div_y (
    .clk(clk), .en(en), .num(y0_r), .den(cell_len), .quo(cy), .rem(fy));
  ckgp_udiv_pipe #(.N_W(12), .D_W(S_W), .Q_W(DEPTH)) u_div_lx (
    .clk(clk), .en(en), .num(lx0_r), .den(p), .quo(qx), .rem());
  ckgp_udiv_pipe #(.N_W(12), .D_W(S_W), .Q_W(DEPTH)) u_div_ly (
    .clk(clk), .en(en), .num(ly0_r), .den(p), .quo(qy), .rem());

  for (genvar i = 0; i < DEPTH; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= (i == 0) ? v0_r : vld_r[(i == 0) ? 0 : i - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= (i == 0) ? f0_r : side_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign loc_valid = vld_r[DEPTH-1];
  assign loc_flags = side_r[DEPTH-1];

endmodule

### rtl/ckgp_shade.sv
// ----------------------------------------------------------------------------
// ckgp_shade
// Grid distance, blend factor, rounded blend division, overlays and the
// output register.
// ----------------------------------------------------------------------------
module ckgp_shade import ckgp_pkg::*; #(
  parameter int S_W = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           loc_valid,
  input  loc_flags_t     loc_flags,
  input  logic [11:0]    cx,
  input  logic [11:0]    cy,
  input  logic [S_W-1:0] fx,
  input  logic [S_W-1:0] fy,
  input  logic [11:0]    qx,
  input  logic [11:0]    qy,
  input  logic [S_W-1:0] cell_len,
  input  logic [S_W-1:0] hn,
  output logic           out_valid,
  output pix_out_t       out_data
);

  localparam int K_W   = S_W + 4;
  localparam int DEN_W = S_W + 5;
  localparam int D_W   = S_W + 6;
  localparam int N_W   = S_W + 13;
  localparam int Q_W   = 8;

  typedef struct packed {
    logic outside;
    logic border;
    logic lab_hit;
    logic line;
    rgb_t base;
  } side_t;

  // Stage E: distance to the nearest cell edge and line classification.
  logic [S_W-1:0] fxm, fym, dmin_a, dmin_b, d;
  logic           line_e, major_e, hit_e;
  logic [S_W+8:0] hn_ext;

  logic           ve_r;
  loc_flags_t     fe_r;
  logic           hit_r, line_r, major_r, par_r;
  logic [S_W-1:0] rem_r;

  assign fxm    = cell_len - S_W'(1) - fx;
  assign fym    = cell_len - S_W'(1) - fy;
  assign dmin_a = (fx < fy) ? fx : fy;
  assign dmin_b = (fxm < fym) ? fxm : fym;
  assign d      = (dmin_a < dmin_b) ? dmin_a : dmin_b;
  assign hn_ext = {9'd0, hn};
  assign line_e = ({d, 9'd0} <= hn_ext);
  assign major_e = ((cx[1:0] == 2'd0) && ({fx, 9'd0} <= hn_ext)) ||
                   ((cy[1:0] == 2'd0) && ({fy, 9'd0} <= hn_ext));
  assign hit_e  = loc_flags.lab_in && label_pix(qx, qy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= loc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fe_r    <= loc_flags;
      hit_r   <= hit_e;
      line_r  <= line_e;
      major_r <= major_e;
      par_r   <= cx[0] ^ cy[0];
      rem_r   <= hn - {d[S_W-10:0], 9'd0};
    end
  end

  // Stage F: weight times remaining distance, and the blend denominator.
  logic             vf_r;
  side_t            sf_r;
  logic [K_W-1:0]   k_r;
  logic [DEN_W-1:0] den_r;
  rgb_t             diff_r;
  rgb_t             base_f, tgt_f;

  assign base_f = par_r ? COL_DARK : COL_LIGHT;
  assign tgt_f  = major_r ? COL_MAJOR : COL_GRID;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf_r   <= '{outside: fe_r.outside, border: fe_r.border, lab_hit: hit_r,
                  line: line_r, base: base_f};
      k_r    <= major_r ? K_W'(rem_r) * K_W'(9) : K_W'(rem_r) * K_W'(11);
      den_r  <= major_r ? DEN_W'(hn) * DEN_W'(10) : DEN_W'(hn) * DEN_W'(20);
      diff_r <= '{r: tgt_f.r - base_f.r, g: tgt_f.g - base_f.g,
                  b: tgt_f.b - base_f.b};
    end
  end

  // Stage G: numerators of the half-up rounded quotient.
  logic           vg_r;
  side_t          sg_r;
  logic [N_W-1:0] num_r_r, num_g_r, num_b_r;
  logic [D_W-1:0] dd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_r    <= sf_r;
      num_r_r <= ((N_W'(diff_r.r) * N_W'(k_r)) << 1) + N_W'(den_r);
      num_g_r <= ((N_W'(diff_r.g) * N_W'(k_r)) << 1) + N_W'(den_r);
      num_b_r <= ((N_W'(diff_r.b) * N_W'(k_r)) << 1) + N_W'(den_r);
      dd_r    <= {den_r, 1'b0};
    end
  end

  logic [Q_W-1:0] q_r, q_g, q_b;

  ckgp_udiv_pipe #(.N_W(N_W), .D_W(D_W), .Q_W(Q_W)) u_div_r (
    .clk(clk), .en(en), .num(num_r_r), .den(dd_r), .quo(q_r), .rem());
  ckgp_udiv_pipe #(.N_W(N_W), .D_W(D_W), .Q_W(Q_W)) u_div_g (
    .clk(clk), .en(en), .num(num_g_r), .den(dd_r), .quo(q_g), .rem());
  ckgp_udiv_pipe #(.N_W(N_W), .D_W(D_W), .Q_W(Q_W)) u_div_b (
    .clk(clk), .en(en), .num(num_b_r), .den(dd_r), .quo(q_b), .rem());

  logic  vld_r [Q_W];
  side_t side_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= (i == 0) ? vg_r : vld_r[(i == 0) ? 0 : i - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= (i == 0) ? sg_r : side_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // Final stage: blend result, then border, label and outside overrides.
  side_t    sd;
  pix_out_t px_nxt;
  logic     out_valid_r;
  pix_out_t out_data_r;

  assign sd = side_r[Q_W-1];

  always_comb begin
    if (sd.line) begin
      px_nxt = '{red: 8'(sd.base.r + q_r), green: 8'(sd.base.g + q_g),
                 blue: 8'(sd.base.b + q_b), outside: 1'b0};
    end else begin
      px_nxt = '{red: sd.base.r, green: sd.base.g, blue: sd.base.b, outside: 1'b0};
    end
    if (sd.border) begin
      px_nxt = '{red: COL_BORDER.r, green: COL_BORDER.g, blue: COL_BORDER.b,
                 outside: 1'b0};
    end
    if (sd.lab_hit) begin
      px_nxt = '{red: COL_TEXT.r, green: COL_TEXT.g, blue: COL_TEXT.b, outside: 1'b0};
    end
    if (sd.outside) begin
      px_nxt = '{red: 8'd0, green: 8'd0, blue: 8'd0, outside: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= px_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/checker_grid_pattern_pixel.sv
// ----------------------------------------------------------------------------
// checker_grid_pattern_pixel
// Throughput: one pixel per cycle; every stage is a register and the whole
//   pipeline holds as one while the result side stalls.
// Reset (synchronous, rst_n low) clears all valid bits and restores the
//   register defaults; then input is stalled while the cell edge is derived.
//   Every configuration write restarts that derivation.
// ----------------------------------------------------------------------------
module checker_grid_pattern_pixel import ckgp_pkg::*; #(
  parameter int MAX_SIZE = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Geometry width: wide enough for the largest size and for the 512 floor
  // of the grid half-width numerator.
  localparam int S_W = ($clog2(MAX_SIZE + 1) < 10) ? 10 : $clog2(MAX_SIZE + 1);

  logic           en;
  logic           accept;
  logic           busy;
  cfg_flags_t     flags;
  logic [S_W-1:0] s, hn, w, s_minus_w, p, cell_len, org;

  logic           loc_valid;
  loc_flags_t     loc_flags;
  logic [11:0]    cx, cy, qx, qy;
  logic [S_W-1:0] fx, fy;

  // The pipeline advances unless a finished beat sits in the output register
  // and the consumer stalls it. New beats are also held off while the
  // geometry is being derived.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en || busy;
  assign accept   = in_valid && !in_stall;

  ckgp_setup #(.MAX_SIZE(MAX_SIZE), .S_W(S_W)) u_setup (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .busy(busy), .flags(flags), .s(s), .hn(hn), .w(w),
    .s_minus_w(s_minus_w), .p(p), .cell_len(cell_len), .org(org));

  // Front half: input register, then four 12-stage dividers for the cell
  // position and the label grid position of the pixel.
  ckgp_locate #(.S_W(S_W)) u_locate (
    .clk(clk), .rst_n(rst_n), .en(en), .accept(accept), .in_data(in_data),
    .flags(flags), .s(s), .w(w), .s_minus_w(s_minus_w), .p(p),
    .cell_len(cell_len), .org(org), .loc_valid(loc_valid),
    .loc_flags(loc_flags), .cx(cx), .cy(cy), .fx(fx), .fy(fy), .qx(qx),
    .qy(qy));

  // Back half: three stages of blend setup, an 8-stage rounding divider per
  // channel, and the output register.
  ckgp_shade #(.S_W(S_W)) u_shade (
    .clk(clk), .rst_n(rst_n), .en(en), .loc_valid(loc_valid),
    .loc_flags(loc_flags), .cx(cx), .cy(cy), .fx(fx), .fy(fy), .qx(qx),
    .qy(qy), .cell_len(cell_len), .hn(hn), .out_valid(out_valid),
    .out_data(out_data));

endmodule

### rtl/ckgp_checker.sv
// ----------------------------------------------------------------------------
// ckgp_checker
// Port-level checks of the checker grid pattern generator, bound to the top.
// ----------------------------------------------------------------------------
module ckgp_checker import ckgp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input pix_out_t out_data,
  input logic     cfg_we
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed or vanished");

  // Outside pixels are black.
  a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outside |->
      out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
    else $error("outside pixel carries color");

  // A register write holds off input while geometry is rederived.
  a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input taken right after a register write");

endmodule

bind checker_grid_pattern_pixel ckgp_checker u_ckgp_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_data(out_data), .cfg_we(cfg_we));
